// ===== design/erc_pkg.sv =====
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types and constants for the elevator request controller: item
// kinds, mode and direction codes, badge code layout and default sizes.
// ----------------------------------------------------------------------------
package erc_pkg;

	// default sizes, handed to the top level as parameter defaults
	localparam int FLOORS_DEF      = 6;
	localparam int BUTTONS_DEF     = 8;
	localparam int PASS_DIGITS_DEF = 4;

	// badge code field and the code that opens password entry
	localparam int              CODE_W     = 3;
	localparam logic [CODE_W-1:0] ENTER_CODE = 3'd6;

	// password progress counter, saturating
	localparam int              PROG_W   = 4;
	localparam logic [PROG_W-1:0] PROG_MAX = 4'd15;

	typedef enum logic {
		OP_POLL = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_INIT   = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_PASS   = 2'd2,
		MODE_SECURE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DIR_UP   = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_IDLE = 2'd2,
		DIR_NONE = 2'd3
	} dir_t;

endpackage

// ===== design/erc_step.sv =====
// ----------------------------------------------------------------------------
// erc_step
// Next-state logic for one word: runs the mode machine on a poll, or moves
// the car one floor and picks the next direction on a tick.
// ----------------------------------------------------------------------------
module erc_step #(
	parameter int FLOORS      = 6,
	parameter int BUTTONS     = 8,
	parameter int PASS_DIGITS = 4,
	localparam int FLOOR_W    = $clog2(FLOORS)
) (
	input  logic                          op,
	input  logic [BUTTONS-1:0]            buttons,
	input  logic                          badge_valid,
	input  logic [erc_pkg::CODE_W-1:0]    badge_code,
	input  erc_pkg::mode_t                cur_mode,
	input  erc_pkg::dir_t                 cur_dir,
	input  logic [FLOOR_W-1:0]            cur_floor,
	input  logic [FLOORS-1:0]             cur_req,
	input  logic                          cur_enter,
	input  logic                          cur_secure,
	input  logic [erc_pkg::PROG_W-1:0]    cur_prog,
	output erc_pkg::mode_t                nxt_mode,
	output erc_pkg::dir_t                 nxt_dir,
	output logic [FLOOR_W-1:0]            nxt_floor,
	output logic [FLOORS-1:0]             nxt_req,
	output logic                          nxt_enter,
	output logic                          nxt_secure,
	output logic [erc_pkg::PROG_W-1:0]    nxt_prog,
	output logic                          stop_here,
	output logic                          beep
);
	import erc_pkg::*;

	localparam int WIDE_W = (FLOORS > BUTTONS) ? FLOORS : BUTTONS;
	localparam int CNT_W  = $clog2(BUTTONS + 1);
	localparam int SUM_W  = ((CNT_W > PROG_W) ? CNT_W : PROG_W) + 1;

	logic [WIDE_W-1:0]  btn_wide;
	logic [FLOORS-1:0]  btn_req;
	logic [FLOORS-1:0]  badge_bit;
	logic [FLOORS-1:0]  floor_bit;
	logic               badge_floor;
	logic               badge_enter;
	logic [FLOOR_W-1:0] mv_floor;
	logic [FLOORS-1:0]  above_mask;
	logic [FLOORS-1:0]  below_mask;
	logic [FLOORS-1:0]  req_shift;
	logic               dem_above;
	logic               dem_below;
	logic [BUTTONS-1:0] run;
	logic               run_prev;
	logic               bad_press;
	logic [CNT_W-1:0]   run_cnt;
	logic [SUM_W-1:0]   prog_sum;
	logic [PROG_W-1:0]  pass_prog;
	logic               enter_now;

	// decode badge and floor one-hots, button requests
	always_comb begin
		btn_wide    = WIDE_W'(buttons);
		btn_req     = btn_wide[FLOORS-1:0];
		badge_floor = badge_valid && (int'(badge_code) < FLOORS);
		badge_enter = badge_valid && !badge_floor && (badge_code == ENTER_CODE);
		for (int i = 0; i < FLOORS; i++) begin
			badge_bit[i] = badge_floor && (int'(badge_code) == i);
			floor_bit[i] = (int'(cur_floor) == i);
		end
		enter_now = cur_enter || badge_enter;
	end

	// move the car one floor and look for demand around the new floor
	always_comb begin
		mv_floor = cur_floor;
		if (cur_dir == DIR_UP && int'(cur_floor) < FLOORS - 1) begin
			mv_floor = cur_floor + FLOOR_W'(1);
		end else if (cur_dir == DIR_DOWN && cur_floor != '0) begin
			mv_floor = cur_floor - FLOOR_W'(1);
		end
		for (int i = 0; i < FLOORS; i++) begin
			above_mask[i] = (i > int'(mv_floor));
			below_mask[i] = (i < int'(mv_floor));
		end
		dem_above = |(cur_req & above_mask);
		dem_below = |(cur_req & below_mask);
		req_shift = cur_req >> mv_floor;
	end

	// password scan: a run of pressed buttons starting at the progress
	// advances it, any other pressed button is a mistake
	always_comb begin
		run_prev = 1'b0;
		for (int i = 0; i < BUTTONS; i++) begin
			run[i] = buttons[i] && ((int'(cur_prog) == i) ||
				((int'(cur_prog) < i) && run_prev));
			run_prev = run[i];
		end
		bad_press = |(buttons & ~run);
		run_cnt   = CNT_W'($countones(run));
		prog_sum  = SUM_W'(cur_prog) + SUM_W'(run_cnt);
		pass_prog = (prog_sum > SUM_W'(PROG_MAX)) ? PROG_MAX : prog_sum[PROG_W-1:0];
	end

	// pick the next state
	always_comb begin
		nxt_mode   = cur_mode;
		nxt_dir    = cur_dir;
		nxt_floor  = cur_floor;
		nxt_req    = cur_req;
		nxt_enter  = cur_enter;
		nxt_secure = cur_secure;
		nxt_prog   = cur_prog;
		stop_here  = 1'b0;
		beep       = 1'b0;
		if (op == OP_TICK) begin
			nxt_floor = mv_floor;
			stop_here = req_shift[0];
			beep      = req_shift[0];
			case (cur_dir)
				DIR_UP: begin
					nxt_dir = dem_above ? DIR_UP : (dem_below ? DIR_DOWN : DIR_IDLE);
				end
				DIR_DOWN: begin
					nxt_dir = dem_below ? DIR_DOWN : (dem_above ? DIR_UP : DIR_IDLE);
				end
				DIR_IDLE: begin
					nxt_dir = dem_above ? DIR_UP : (dem_below ? DIR_DOWN : DIR_IDLE);
				end
				default: begin
					nxt_dir = cur_dir;
				end
			endcase
		end else begin
			case (cur_mode)
				MODE_INIT: begin
					beep     = 1'b1;
					nxt_req  = '0;
					nxt_mode = cur_secure ? MODE_SECURE : MODE_NORMAL;
				end
				MODE_NORMAL: begin
					nxt_req   = ((cur_req | btn_req) & ~floor_bit) | badge_bit;
					nxt_enter = enter_now;
					beep      = badge_enter;
					if (enter_now) begin
						nxt_prog = '0;
						nxt_req  = '0;
						nxt_mode = MODE_PASS;
					end
				end
				MODE_SECURE: begin
					nxt_req   = (cur_req | badge_bit) & ~floor_bit;
					nxt_enter = enter_now;
					beep      = badge_enter;
					if (enter_now) begin
						nxt_prog = '0;
						nxt_req  = '0;
						nxt_mode = MODE_PASS;
					end
				end
				MODE_PASS: begin
					nxt_enter = 1'b0;
					nxt_prog  = pass_prog;
					if (pass_prog == PROG_W'(PASS_DIGITS)) begin
						nxt_secure = !cur_secure;
						nxt_mode   = MODE_INIT;
					end else if (bad_press) begin
						nxt_mode = MODE_INIT;
					end
				end
				default: begin
					nxt_mode = cur_mode;
				end
			endcase
		end
	end

endmodule

// ===== design/elevator_request_controller.sv =====
// ----------------------------------------------------------------------------
// elevator_request_controller
// Elevator mode machine, request bitmap and car motion, one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word: op selects a poll
//   (buttons and badge run the mode machine) or a timer tick (the car moves
//   one floor and picks its next direction).
//   Output channel (out_valid / out_stall) returns exactly one word per input
//   word: floor, direction, mode, requests and secure flag after that word,
//   plus stop_here and beep pulses.
//   Path: a taken word is registered in the input register, then processed
//   into the state and the result register, where its result shows valid.
//   Throughput: one word per cycle unless out_stall holds a result; the
//   state update is a single pass of mask and compare logic between the
//   input register and the state.
//   Stall: when out_stall holds a result, the input register keeps its word
//   and in_stall rises only once that register is full; nothing is dropped.
//   Reset: arst_n clears both valids and sets mode init, direction idle,
//   floor 0, no requests, secure off and password progress 0.
// ----------------------------------------------------------------------------
module elevator_request_controller #(
	parameter int FLOORS      = erc_pkg::FLOORS_DEF,
	parameter int BUTTONS     = erc_pkg::BUTTONS_DEF,
	parameter int PASS_DIGITS = erc_pkg::PASS_DIGITS_DEF,
	localparam int FLOOR_W    = $clog2(FLOORS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [BUTTONS-1:0]         buttons,
	input  logic                       badge_valid,
	input  logic [erc_pkg::CODE_W-1:0] badge_code,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [FLOOR_W-1:0]         floor,
	output logic [1:0]                 direction,
	output logic [1:0]                 mode,
	output logic [FLOORS-1:0]          requests,
	output logic                       secure_on,
	output logic                       stop_here,
	output logic                       beep
);
	import erc_pkg::*;

	// input register
	logic                 valid_s1;
	logic                 op_s1;
	logic [BUTTONS-1:0]   buttons_s1;
	logic                 badge_valid_s1;
	logic [CODE_W-1:0]    badge_code_s1;

	// controller state
	mode_t                mode_q;
	dir_t                 dir_q;
	logic [FLOOR_W-1:0]   floor_q;
	logic [FLOORS-1:0]    req_q;
	logic                 enter_q;
	logic                 secure_q;
	logic [PROG_W-1:0]    prog_q;

	// next state
	mode_t                mode_d;
	dir_t                 dir_d;
	logic [FLOOR_W-1:0]   floor_d;
	logic [FLOORS-1:0]    req_d;
	logic                 enter_d;
	logic                 secure_d;
	logic [PROG_W-1:0]    prog_d;
	logic                 stop_d;
	logic                 beep_d;

	// result register
	logic                 out_valid_q;
	logic [FLOOR_W-1:0]   floor_out_q;
	logic [1:0]           dir_out_q;
	logic [1:0]           mode_out_q;
	logic [FLOORS-1:0]    req_out_q;
	logic                 secure_out_q;
	logic                 stop_out_q;
	logic                 beep_out_q;

	logic                 advance;

	// move a word on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// hold or load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1          <= op;
			buttons_s1     <= buttons;
			badge_valid_s1 <= badge_valid;
			badge_code_s1  <= badge_code;
		end
	end

	erc_step #(
		.FLOORS      (FLOORS),
		.BUTTONS     (BUTTONS),
		.PASS_DIGITS (PASS_DIGITS)
	) u_step (
		.op          (op_s1),
		.buttons     (buttons_s1),
		.badge_valid (badge_valid_s1),
		.badge_code  (badge_code_s1),
		.cur_mode    (mode_q),
		.cur_dir     (dir_q),
		.cur_floor   (floor_q),
		.cur_req     (req_q),
		.cur_enter   (enter_q),
		.cur_secure  (secure_q),
		.cur_prog    (prog_q),
		.nxt_mode    (mode_d),
		.nxt_dir     (dir_d),
		.nxt_floor   (floor_d),
		.nxt_req     (req_d),
		.nxt_enter   (enter_d),
		.nxt_secure  (secure_d),
		.nxt_prog    (prog_d),
		.stop_here   (stop_d),
		.beep        (beep_d)
	);

	// advance the controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_INIT;
			dir_q    <= DIR_IDLE;
			floor_q  <= '0;
			req_q    <= '0;
			enter_q  <= 1'b0;
			secure_q <= 1'b0;
			prog_q   <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			dir_q    <= dir_d;
			floor_q  <= floor_d;
			req_q    <= req_d;
			enter_q  <= enter_d;
			secure_q <= secure_d;
			prog_q   <= prog_d;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			floor_out_q  <= floor_d;
			dir_out_q    <= dir_d;
			mode_out_q   <= mode_d;
			req_out_q    <= req_d;
			secure_out_q <= secure_d;
			stop_out_q   <= stop_d;
			beep_out_q   <= beep_d;
		end
	end

	assign out_valid = out_valid_q;
	assign floor     = floor_out_q;
	assign direction = dir_out_q;
	assign mode      = mode_out_q;
	assign requests  = req_out_q;
	assign secure_on = secure_out_q;
	assign stop_here = stop_out_q;
	assign beep      = beep_out_q;

endmodule
